// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

// File: rtl/dedb_pkg.sv
package dedb_pkg;

  localparam int unsigned NUM_EVENTS   = 64;
  localparam int unsigned MEMORY_SLOTS = 16;

  localparam int unsigned EV_AW     = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int unsigned TOT_W     = $clog2(MEMORY_SLOTS + 1);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW    = 16;

  // Status byte bits.
  localparam logic [7:0] SB_TF     = 8'h01;
  localparam logic [7:0] SB_TFTOC  = 8'h02;
  localparam logic [7:0] SB_PDTC   = 8'h04;
  localparam logic [7:0] SB_CDTC   = 8'h08;
  localparam logic [7:0] SB_TNCSLC = 8'h10;
  localparam logic [7:0] SB_TFSLC  = 8'h20;
  localparam logic [7:0] SB_TNCTOC = 8'h40;
  localparam logic [7:0] SB_RESET  = 8'h50;

  localparam logic [15:0] OCC_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_REPORT      = 3'd0,
    MODE_RESET_EV    = 3'd1,
    MODE_CLEAR_ALL   = 3'd2,
    MODE_CYCLE_START = 3'd3,
    MODE_READ        = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    RES_PASSED    = 2'd0,
    RES_FAILED    = 2'd1,
    RES_PREPASSED = 2'd2,
    RES_PREFAILED = 2'd3
  } result_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE   = 3'd0,
    CFG_DTC_EN   = 3'd1,
    CFG_PASS_THR = 3'd2,
    CFG_FAIL_THR = 3'd3,
    CFG_PREPASS  = 3'd4,
    CFG_PREFAIL  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_SWEEP = 2'd2
  } state_e;

  typedef struct packed {
    logic [7:0]         status;
    logic signed [15:0] debounce;
    logic [15:0]        occ;
    logic               stored;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{status: SB_RESET, debounce: 16'sd0,
                                     occ: 16'd0, stored: 1'b0};

  typedef struct packed {
    logic               active;
    logic               dtc_en;
    logic signed [15:0] pass_thr;
    logic [14:0]        fail_thr;
    logic [14:0]        prepass;
    logic [14:0]        prefail;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [EV_AW-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic             en;
    logic [EV_AW-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic   err;
    logic   wr_en;
    entry_t ent;
    logic   tot_inc;
  } upd_t;

  function automatic logic [7:0] cycle_start_status(logic [7:0] s);
    return (s & ~SB_TFTOC) | SB_TNCTOC;
  endfunction

endpackage

// File: rtl/dedb_table.sv
module dedb_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dedb_pkg::tbl_rd_t rd_i,
  input  dedb_pkg::tbl_wr_t wr_i,
  input  logic             clr_all_i,
  output dedb_pkg::entry_t  rd_data_o
);

  dedb_pkg::entry_t mem_q [dedb_pkg::NUM_EVENTS];
  logic [dedb_pkg::NUM_EVENTS-1:0] vld_q;
  dedb_pkg::entry_t rd_ent_q;
  logic rd_vld_q;
  logic same_addr;

  assign same_addr = wr_i.en && (wr_i.addr == rd_i.addr);

  // A read of the entry written at the same edge returns the new data.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      if (same_addr) begin
        rd_ent_q <= wr_i.data;
      end else begin
        rd_ent_q <= mem_q[rd_i.addr];
      end
    end
  end

  // Entries never written since reset or clear-all read as reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_all_i) begin
        vld_q <= '0;
      end else if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_vld_q <= same_addr ? 1'b1 : vld_q[rd_i.addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_ent_q : dedb_pkg::ENTRY_RESET;

endmodule

// File: rtl/dedb_update.sv
module dedb_update (
  input  dedb_pkg::cfg_t             cfg_i,
  input  logic [2:0]                 mode_i,
  input  logic [1:0]                 kind_i,
  input  logic                       id_valid_i,
  input  dedb_pkg::entry_t           ent_i,
  input  logic [dedb_pkg::TOT_W-1:0] total_i,
  output dedb_pkg::upd_t             upd_o
);

  logic signed [17:0] deb_x, pass_x, fail_x, v;
  logic failed, qual;
  logic [7:0] s;
  dedb_pkg::entry_t rep_ent;
  logic rep_inc;

  // Debounce step and status qualification of a result report.
  always_comb begin
    deb_x  = 18'(ent_i.debounce);
    pass_x = 18'(cfg_i.pass_thr);
    fail_x = {3'b000, cfg_i.fail_thr};
    failed = 1'b0;
    v      = deb_x;
    case (kind_i)
      dedb_pkg::RES_PASSED: v = pass_x;
      dedb_pkg::RES_FAILED: begin
        v      = fail_x;
        failed = 1'b1;
      end
      dedb_pkg::RES_PREPASSED: begin
        v = deb_x - $signed({3'b000, cfg_i.prepass});
        if (v <= pass_x) begin
          v = pass_x;
        end
      end
      default: begin
        v = deb_x + $signed({3'b000, cfg_i.prefail});
        if (v >= fail_x) begin
          v      = fail_x;
          failed = 1'b1;
        end
      end
    endcase
    // Every branch above leaves v inside 16 signed bits.
    qual = (v <= pass_x) || (v >= fail_x);

    rep_ent          = ent_i;
    rep_ent.debounce = v[15:0];
    rep_inc          = 1'b0;
    s                = ent_i.status & ~dedb_pkg::SB_TNCTOC;
    if (failed) begin
      s = (s | dedb_pkg::SB_TF | dedb_pkg::SB_TFTOC | dedb_pkg::SB_TFSLC | dedb_pkg::SB_PDTC)
          & ~dedb_pkg::SB_TNCSLC;
      if (ent_i.occ != dedb_pkg::OCC_MAX) begin
        rep_ent.occ = ent_i.occ + 16'd1;
      end
      if (!ent_i.stored && (total_i < dedb_pkg::TOT_W'(dedb_pkg::MEMORY_SLOTS))) begin
        rep_ent.stored = 1'b1;
        rep_inc        = 1'b1;
        s              = s | dedb_pkg::SB_CDTC;
      end
    end else begin
      s = s & ~(dedb_pkg::SB_TF | dedb_pkg::SB_TFTOC);
    end
    if (qual) begin
      rep_ent.status = s;
    end else begin
      rep_ent.occ    = ent_i.occ;
      rep_ent.stored = ent_i.stored;
      rep_inc        = 1'b0;
    end
  end

  // Mode decode and error checks; table-wide modes are run by the sequencer.
  always_comb begin
    upd_o = '{err: 1'b0, wr_en: 1'b0, ent: ent_i, tot_inc: 1'b0};
    if (!cfg_i.active) begin
      upd_o.err = 1'b1;
    end else begin
      case (mode_i) inside
        dedb_pkg::MODE_REPORT: begin
          if (!id_valid_i || !cfg_i.dtc_en) begin
            upd_o.err = 1'b1;
          end else begin
            upd_o.wr_en   = 1'b1;
            upd_o.ent     = rep_ent;
            upd_o.tot_inc = rep_inc;
          end
        end
        dedb_pkg::MODE_RESET_EV: begin
          if (!id_valid_i) begin
            upd_o.err = 1'b1;
          end else begin
            upd_o.wr_en        = 1'b1;
            upd_o.ent.status   = dedb_pkg::SB_RESET;
            upd_o.ent.debounce = 16'sd0;
          end
        end
        dedb_pkg::MODE_CLEAR_ALL, dedb_pkg::MODE_CYCLE_START: begin
        end
        dedb_pkg::MODE_READ: begin
          if (!id_valid_i) begin
            upd_o.err = 1'b1;
          end
        end
        default: upd_o.err = 1'b1;
      endcase
    end
  end

endmodule

// File: rtl/diagnostic_event_debounce_status.sv
// Diagnostic event table with counter-based debounce and UDS status bytes.
// Input channel (in_valid_i/in_ready_o) carries one item: mode, event_id and
// event_result. Output channel (out_valid_o/out_ready_i) returns exactly one
// result item per input item, in order: error, status_byte, occurrence_count
// and stored_count, all taken after the item has taken effect.
// Every item but an active cycle start first reads the event table memory
// through its registered read; the update, any write-back of the entry and
// the result register follow together. Cycle start walks every table entry
// through the single read/write port, one per cycle, then rereads the
// addressed event. One item is in work at a time: no new item is taken
// until the last one has registered its result. Clear-all drops all
// per-entry valid bits at once.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i),
// to be used only while the block is idle.
// Reset clears all valid bits, so every event reads as status 0x50 with zero
// debounce and occurrence count; configuration and control registers return to their defaults.
// While the receiver stalls, the result waits in the output register; the
// block holds the next item in its update stage; only a sweep writes the table.
`include "assert_macros.svh"

module diagnostic_event_debounce_status (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dedb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dedb_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     mode_i,
  input  logic [7:0]                     event_id_i,
  input  logic [1:0]                     event_result_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           error_o,
  output logic [7:0]                     status_byte_o,
  output logic [15:0]                    occurrence_count_o,
  output logic [6:0]                     stored_count_o
);

  localparam int unsigned AW = dedb_pkg::EV_AW;
  localparam int unsigned TW = dedb_pkg::TOT_W;

  dedb_pkg::cfg_t   cfg_q;
  dedb_pkg::state_e state_q, state_d;
  logic [2:0]       mode_q;
  logic [7:0]       id_q;
  logic [1:0]       kind_q;
  logic [AW-1:0]    cnt_q;
  logic             sweep_done_q;
  logic [TW-1:0]    total_q, total_d;
  logic             out_valid_q;
  logic             out_err_q;
  logic [7:0]       out_status_q;
  logic [15:0]      out_occ_q;
  logic [6:0]       out_stored_q;

  dedb_pkg::tbl_rd_t tbl_rd;
  dedb_pkg::tbl_wr_t tbl_wr;
  dedb_pkg::entry_t  rd_ent;
  dedb_pkg::upd_t    upd;
  logic              clr_all;
  logic              id_valid;
  logic              start_sweep;
  logic              finish;
  logic              last;
  logic              accept;

  dedb_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (tbl_rd),
    .wr_i      (tbl_wr),
    .clr_all_i (clr_all),
    .rd_data_o (rd_ent)
  );

  dedb_update u_update (
    .cfg_i      (cfg_q),
    .mode_i     (mode_q),
    .kind_i     (kind_q),
    .id_valid_i (id_valid),
    .ent_i      (rd_ent),
    .total_i    (total_q),
    .upd_o      (upd)
  );

  assign id_valid    = {1'b0, id_q} < 9'(dedb_pkg::NUM_EVENTS);
  assign start_sweep = (mode_q == dedb_pkg::MODE_CYCLE_START) && cfg_q.active
                       && !sweep_done_q;
  assign finish      = (state_q == dedb_pkg::S_EXEC) && !start_sweep
                       && (!out_valid_q || out_ready_i);
  assign last        = cnt_q == AW'(dedb_pkg::NUM_EVENTS - 1);
  assign accept      = in_valid_i && in_ready_o;
  assign clr_all     = finish && (mode_q == dedb_pkg::MODE_CLEAR_ALL) && cfg_q.active;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dedb_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = dedb_pkg::S_EXEC;
        end
      end
      dedb_pkg::S_EXEC: begin
        if (start_sweep) begin
          state_d = dedb_pkg::S_SWEEP;
        end else if (finish) begin
          state_d = dedb_pkg::S_IDLE;
        end
      end
      dedb_pkg::S_SWEEP: begin
        if (last) begin
          state_d = dedb_pkg::S_EXEC;
        end
      end
      default: state_d = dedb_pkg::S_IDLE;
    endcase
  end

  // Table port control.
  always_comb begin
    in_ready_o = 1'b0;
    tbl_rd     = '{en: 1'b0, addr: event_id_i[AW-1:0]};
    tbl_wr     = '{en: 1'b0, addr: id_q[AW-1:0], data: upd.ent};
    unique case (state_q)
      dedb_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        tbl_rd.en  = in_valid_i;
      end
      dedb_pkg::S_EXEC: begin
        if (start_sweep) begin
          tbl_rd = '{en: 1'b1, addr: '0};
        end
        tbl_wr.en = finish && upd.wr_en;
      end
      dedb_pkg::S_SWEEP: begin
        // The last sweep step rereads the addressed event for the result.
        tbl_rd.en   = 1'b1;
        tbl_rd.addr = last ? id_q[AW-1:0] : cnt_q + AW'(1);
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = cnt_q;
        tbl_wr.data = rd_ent;
        tbl_wr.data.status = dedb_pkg::cycle_start_status(rd_ent.status);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    total_d = total_q;
    if (clr_all) begin
      total_d = '0;
    end else if (finish && upd.tot_inc) begin
      total_d = total_q + TW'(1);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{active: 1'b1, dtc_en: 1'b1, pass_thr: -16'sd128,
                 fail_thr: 15'd127, prepass: 15'd1, prefail: 15'd1};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dedb_pkg::CFG_ACTIVE:   cfg_q.active   <= cfg_wdata_i[0];
        dedb_pkg::CFG_DTC_EN:   cfg_q.dtc_en   <= cfg_wdata_i[0];
        dedb_pkg::CFG_PASS_THR: cfg_q.pass_thr <= cfg_wdata_i;
        dedb_pkg::CFG_FAIL_THR: cfg_q.fail_thr <= cfg_wdata_i[14:0];
        dedb_pkg::CFG_PREPASS:  cfg_q.prepass  <= cfg_wdata_i[14:0];
        dedb_pkg::CFG_PREFAIL:  cfg_q.prefail  <= cfg_wdata_i[14:0];
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dedb_pkg::S_IDLE;
      cnt_q        <= '0;
      sweep_done_q <= 1'b0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (accept) begin
        sweep_done_q <= 1'b0;
      end else if ((state_q == dedb_pkg::S_SWEEP) && last) begin
        sweep_done_q <= 1'b1;
      end
      if (start_sweep && (state_q == dedb_pkg::S_EXEC)) begin
        cnt_q <= '0;
      end else if (state_q == dedb_pkg::S_SWEEP) begin
        cnt_q <= cnt_q + AW'(1);
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      id_q   <= event_id_i;
      kind_q <= event_result_i;
    end
    if (finish) begin
      out_err_q    <= upd.err;
      out_stored_q <= 7'(total_d);
      if (!id_valid) begin
        out_status_q <= 8'd0;
        out_occ_q    <= 16'd0;
      end else if (clr_all) begin
        out_status_q <= dedb_pkg::SB_RESET;
        out_occ_q    <= 16'd0;
      end else begin
        out_status_q <= upd.ent.status;
        out_occ_q    <= upd.ent.occ;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign error_o            = out_err_q;
  assign status_byte_o      = out_status_q;
  assign occurrence_count_o = out_occ_q;
  assign stored_count_o     = out_stored_q;

  `ASSERT_PROP(a_total_bound, clk_i, rst_ni, total_q <= TW'(dedb_pkg::MEMORY_SLOTS))
  `ASSERT_PROP(a_accept_exec, clk_i, rst_ni, accept |=> (state_q == dedb_pkg::S_EXEC))
  `ASSERT_NEVER(a_idle_no_write, clk_i, rst_ni, (state_q == dedb_pkg::S_IDLE) && tbl_wr.en)
  `ASSERT_PROP(a_sweep_end, clk_i, rst_ni, ((state_q == dedb_pkg::S_SWEEP) && last) |=> ((state_q == dedb_pkg::S_EXEC) && sweep_done_q))

endmodule

// File: test/diagnostic_event_debounce_status_tb.sv
module diagnostic_event_debounce_status_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTED = 100;
  localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;

  typedef struct packed {
    logic        err;
    logic [7:0]  status;
    logic [15:0] occ;
    logic [6:0]  stored;
  } dtc_result_t;

  class event_status_scoreboard;
    bit active;
    bit dtc_en;
    int pass_lim;
    int fail_lim;
    int step_down;
    int step_up;

    logic [7:0]         ev_status[dedb_pkg::NUM_EVENTS];
    logic signed [15:0] ev_debounce[dedb_pkg::NUM_EVENTS];
    logic [15:0]        ev_occ[dedb_pkg::NUM_EVENTS];
    bit                 ev_stored[dedb_pkg::NUM_EVENTS];
    int unsigned        stored_total;

    dtc_result_t expected_status_q[$];
    int unsigned failures;
    int unsigned results_checked;
    int unsigned rejected;
    int unsigned mode_seen[8];
    int unsigned peak_stored;
    int unsigned peak_occ;

    function new();
      active = 1'b1;
      dtc_en = 1'b1;
      pass_lim = -128;
      fail_lim = 127;
      step_down = 1;
      step_up = 1;
      clear_event_memory();
    endfunction

    function void clear_event_memory();
      for (int i = 0; i < dedb_pkg::NUM_EVENTS; i++) begin
        ev_status[i] = dedb_pkg::SB_RESET;
        ev_debounce[i] = '0;
        ev_occ[i] = '0;
        ev_stored[i] = 1'b0;
      end
      stored_total = 0;
    endfunction

    function void write_reg(dedb_pkg::cfg_idx_e idx, logic [15:0] d);
      case (idx)
        dedb_pkg::CFG_ACTIVE:   active = d[0];
        dedb_pkg::CFG_DTC_EN:   dtc_en = d[0];
        dedb_pkg::CFG_PASS_THR: pass_lim = int'($signed(d));
        dedb_pkg::CFG_FAIL_THR: fail_lim = int'(d[14:0]);
        dedb_pkg::CFG_PREPASS:  step_down = int'(d[14:0]);
        dedb_pkg::CFG_PREFAIL:  step_up = int'(d[14:0]);
        default: ;
      endcase
    endfunction

    // Works out the status of the addressed event after one accepted item.
    function void predict_event_status(logic [2:0] m, logic [7:0] id, logic [1:0] r);
      dtc_result_t want;
      bit id_ok;
      bit fail_q;
      int v;
      logic [7:0] s;
      id_ok = id < dedb_pkg::NUM_EVENTS;
      want.err = 1'b0;
      mode_seen[m]++;
      if (!active) begin
        want.err = 1'b1;
      end else begin
        case (m)
          dedb_pkg::MODE_REPORT: begin
            if (!id_ok || !dtc_en) begin
              want.err = 1'b1;
            end else begin
              v = int'(ev_debounce[id]);
              fail_q = 1'b0;
              case (r)
                dedb_pkg::RES_PASSED: v = pass_lim;
                dedb_pkg::RES_FAILED: begin
                  v = fail_lim;
                  fail_q = 1'b1;
                end
                dedb_pkg::RES_PREPASSED: begin
                  v = v - step_down;
                  if (v <= pass_lim) v = pass_lim;
                end
                default: begin
                  v = v + step_up;
                  if (v >= fail_lim) begin
                    v = fail_lim;
                    fail_q = 1'b1;
                  end
                end
              endcase
              if (v > 32767) v = 32767;
              if (v < -32768) v = -32768;
              ev_debounce[id] = 16'(v);
              if (v <= pass_lim || v >= fail_lim) begin
                s = ev_status[id] & ~dedb_pkg::SB_TNCTOC;
                if (fail_q) begin
                  s = (s | dedb_pkg::SB_TF | dedb_pkg::SB_TFTOC | dedb_pkg::SB_TFSLC
                       | dedb_pkg::SB_PDTC) & ~dedb_pkg::SB_TNCSLC;
                  if (ev_occ[id] != dedb_pkg::OCC_MAX) ev_occ[id] = ev_occ[id] + 16'd1;
                  if (!ev_stored[id] && stored_total < dedb_pkg::MEMORY_SLOTS) begin
                    ev_stored[id] = 1'b1;
                    stored_total++;
                    s = s | dedb_pkg::SB_CDTC;
                  end
                end else begin
                  s = s & ~(dedb_pkg::SB_TF | dedb_pkg::SB_TFTOC);
                end
                ev_status[id] = s;
              end
            end
          end
          dedb_pkg::MODE_RESET_EV: begin
            if (!id_ok) begin
              want.err = 1'b1;
            end else begin
              ev_status[id] = dedb_pkg::SB_RESET;
              ev_debounce[id] = '0;
            end
          end
          dedb_pkg::MODE_CLEAR_ALL: clear_event_memory();
          dedb_pkg::MODE_CYCLE_START: begin
            for (int i = 0; i < dedb_pkg::NUM_EVENTS; i++)
              ev_status[i] = (ev_status[i] & ~dedb_pkg::SB_TFTOC) | dedb_pkg::SB_TNCTOC;
          end
          dedb_pkg::MODE_READ: want.err = !id_ok;
          default: want.err = 1'b1;
        endcase
      end
      want.status = id_ok ? ev_status[id] : 8'h00;
      want.occ = id_ok ? ev_occ[id] : 16'h0000;
      want.stored = 7'(stored_total);
      if (want.err) rejected++;
      if (stored_total > peak_stored) peak_stored = stored_total;
      if (want.occ > peak_occ) peak_occ = 32'(want.occ);
      expected_status_q.push_back(want);
    endfunction

    function void flag_field(string name, logic [15:0] want, logic [15:0] got);
      failures++;
      if (failures <= MAX_PRINTED)
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
    endfunction

    function void check_status_result(dtc_result_t got);
      dtc_result_t want;
      if (expected_status_q.size() == 0) begin
        failures++;
        $error("result item arrived with no item outstanding");
        return;
      end
      want = expected_status_q.pop_front();
      results_checked++;
      if (got.err !== want.err)
        flag_field("error", 16'(want.err), 16'(got.err));
      if (got.status !== want.status)
        flag_field("status_byte", 16'(want.status), 16'(got.status));
      if (got.occ !== want.occ)
        flag_field("occurrence_count", want.occ, got.occ);
      if (got.stored !== want.stored)
        flag_field("stored_count", 16'(want.stored), 16'(got.stored));
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [dedb_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [dedb_pkg::CFG_DW-1:0]    cfg_wdata_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [2:0]                     mode_i;
  logic [7:0]                     event_id_i;
  logic [1:0]                     event_result_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic                           error_o;
  logic [7:0]                     status_byte_o;
  logic [15:0]                    occurrence_count_o;
  logic [6:0]                     stored_count_o;

  event_status_scoreboard sb = new();

  int snd_idle_pct = 6;
  int rcv_idle_pct = 72;
  int hold_req = 0;
  int stall_cycles;

  diagnostic_event_debounce_status DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .event_id_i         (event_id_i),
    .event_result_i     (event_result_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .error_o            (error_o),
    .status_byte_o      (status_byte_o),
    .occurrence_count_o (occurrence_count_o),
    .stored_count_o     (stored_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_status_result({error_o, status_byte_o, occurrence_count_o, stored_count_o});
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("diagnostic_event_debounce_status_tb failed");
    $finish;
  end

  // Valid stays high across back-to-back items; it only drops for a gap or a drain.
  task automatic send_item(logic [2:0] m, logic [7:0] id, logic [1:0] r);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    event_id_i <= id;
    event_result_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.predict_event_status(m, id, r);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic configure(int act, int dtc, int pass_thr, int fail_thr, int dn, int up);
    logic [15:0] vals[6];
    vals[dedb_pkg::CFG_ACTIVE] = 16'(act);
    vals[dedb_pkg::CFG_DTC_EN] = 16'(dtc);
    vals[dedb_pkg::CFG_PASS_THR] = 16'(pass_thr);
    vals[dedb_pkg::CFG_FAIL_THR] = 16'(fail_thr);
    vals[dedb_pkg::CFG_PREPASS] = 16'(dn);
    vals[dedb_pkg::CFG_PREFAIL] = 16'(up);
    for (int i = 0; i < 6; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= dedb_pkg::cfg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      sb.write_reg(dedb_pkg::cfg_idx_e'(i), vals[i]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int n);
    int sent;
    int len;
    int pick;
    logic [7:0] id;
    logic [1:0] kind;
    logic [2:0] m;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // A run of identical reports walks one event's debounce value toward a threshold.
        id = ($urandom_range(3) == 0) ? 8'($urandom_range(63)) : 8'($urandom_range(23));
        kind = 2'($urandom_range(3));
        len = $urandom_range(1, 6);
        repeat (len) begin
          send_item(dedb_pkg::MODE_REPORT, id, kind);
          sent++;
        end
      end else begin
        id = ($urandom_range(6) == 0) ? 8'($urandom_range(255, 64)) : 8'($urandom_range(63));
        pick = $urandom_range(99);
        if (pick < 35) m = dedb_pkg::MODE_READ;
        else if (pick < 55) m = dedb_pkg::MODE_RESET_EV;
        else if (pick < 67) m = dedb_pkg::MODE_CYCLE_START;
        else if (pick < 69) m = dedb_pkg::MODE_CLEAR_ALL;
        else if (pick < 80) m = MODE_FIRST_UNUSED + 3'($urandom_range(2));
        else m = dedb_pkg::MODE_REPORT;
        send_item(m, id, 2'($urandom_range(3)));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    mode_i = '0;
    event_id_i = '0;
    event_result_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: range edges of the event id, every mode, and the error cases.
    configure(1, 1, -128, 127, 1, 1);
    send_item(dedb_pkg::MODE_READ, 8'd0, dedb_pkg::RES_PASSED);
    send_item(dedb_pkg::MODE_READ, 8'd63, dedb_pkg::RES_PASSED);
    send_item(dedb_pkg::MODE_READ, 8'd64, dedb_pkg::RES_PASSED);
    send_item(dedb_pkg::MODE_READ, 8'd255, dedb_pkg::RES_FAILED);
    send_item(dedb_pkg::MODE_REPORT, 8'd0, dedb_pkg::RES_FAILED);
    send_item(dedb_pkg::MODE_REPORT, 8'd0, dedb_pkg::RES_PASSED);
    send_item(dedb_pkg::MODE_REPORT, 8'd1, dedb_pkg::RES_PREFAILED);
    send_item(dedb_pkg::MODE_REPORT, 8'd1, dedb_pkg::RES_PREPASSED);
    send_item(dedb_pkg::MODE_REPORT, 8'd64, dedb_pkg::RES_FAILED);
    send_item(dedb_pkg::MODE_REPORT, 8'd255, dedb_pkg::RES_PREFAILED);
    send_item(dedb_pkg::MODE_CYCLE_START, 8'd255, dedb_pkg::RES_PASSED);
    send_item(dedb_pkg::MODE_READ, 8'd0, dedb_pkg::RES_PASSED);
    send_item(dedb_pkg::MODE_RESET_EV, 8'd0, dedb_pkg::RES_PASSED);
    send_item(dedb_pkg::MODE_RESET_EV, 8'd128, dedb_pkg::RES_PASSED);
    for (int k = 0; k < 3; k++)
      send_item(MODE_FIRST_UNUSED + 3'(k), 8'd3, dedb_pkg::RES_FAILED);
    send_item(dedb_pkg::MODE_REPORT, 8'd63, dedb_pkg::RES_FAILED);
    send_item(dedb_pkg::MODE_CLEAR_ALL, 8'd200, dedb_pkg::RES_PASSED);
    send_item(dedb_pkg::MODE_READ, 8'd63, dedb_pkg::RES_PASSED);

    // Widest thresholds and steps: the prepassed path hits the lower clamp.
    drain_results();
    configure(1, 1, 'h8000, 'h7FFF, 'h7FFF, 'h7FFF);
    send_item(dedb_pkg::MODE_REPORT, 8'd2, dedb_pkg::RES_PREFAILED);
    repeat (3) send_item(dedb_pkg::MODE_REPORT, 8'd2, dedb_pkg::RES_PREPASSED);

    // Narrowest thresholds.
    drain_results();
    configure(1, 1, -1, 1, 1, 1);
    send_item(dedb_pkg::MODE_REPORT, 8'd3, dedb_pkg::RES_PREFAILED);
    repeat (2) send_item(dedb_pkg::MODE_REPORT, 8'd3, dedb_pkg::RES_PREPASSED);

    // Block inactive: everything is rejected.
    drain_results();
    configure(0, 1, -1, 1, 1, 1);
    send_item(dedb_pkg::MODE_READ, 8'd0, dedb_pkg::RES_PASSED);
    send_item(dedb_pkg::MODE_REPORT, 8'd0, dedb_pkg::RES_FAILED);
    send_item(dedb_pkg::MODE_CLEAR_ALL, 8'd0, dedb_pkg::RES_PASSED);
    send_item(dedb_pkg::MODE_CYCLE_START, 8'd0, dedb_pkg::RES_PASSED);
    send_item(dedb_pkg::MODE_READ, 8'd70, dedb_pkg::RES_PASSED);

    // DTC setting off: only reports are rejected.
    drain_results();
    configure(1, 0, -1, 1, 1, 1);
    send_item(dedb_pkg::MODE_REPORT, 8'd4, dedb_pkg::RES_FAILED);
    send_item(dedb_pkg::MODE_READ, 8'd4, dedb_pkg::RES_PASSED);
    send_item(dedb_pkg::MODE_RESET_EV, 8'd4, dedb_pkg::RES_PASSED);
    send_item(dedb_pkg::MODE_CYCLE_START, 8'd4, dedb_pkg::RES_PASSED);

    snd_idle_pct = 6;
    rcv_idle_pct = 72;
    drain_results();
    configure(1, 1, -4, 4, 1, 1);
    run_random(60);
    // Long result stall while items keep coming, so the input side backs up.
    hold_req = 300;
    run_random(140);
    drain_results();
    configure(1, 1, -2, 6, 1, 2);
    run_random(200);

    snd_idle_pct = 72;
    rcv_idle_pct = 6;
    drain_results();
    configure(1, 1, 'h8000, 'h7FFF, 16384, 'h7FFF);
    run_random(100);
    drain_results();
    run_random(100);
    drain_results();
    configure(1, 1, -1, 1, 1, 1);
    run_random(200);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    // Settings outside the documented ranges: positive pass threshold, a zero step.
    drain_results();
    configure(1, 1, 3, 'h8000, 0, 5);
    run_random(200);
    drain_results();
    configure(1, 1, -int'($urandom_range(1, 8)), int'($urandom_range(1, 8)),
              int'($urandom_range(1, 4)), int'($urandom_range(1, 4)));
    run_random(200);

    drain_results();
    repeat (dedb_pkg::NUM_EVENTS + 8) @(posedge clk_i);
    if (sb.expected_status_q.size() != 0) begin
      sb.failures++;
      $error("%0d result items never arrived", sb.expected_status_q.size());
    end

    $display("Checked %0d results: %0d reports, %0d reads, %0d event resets, %0d clears,",
             sb.results_checked, sb.mode_seen[dedb_pkg::MODE_REPORT],
             sb.mode_seen[dedb_pkg::MODE_READ], sb.mode_seen[dedb_pkg::MODE_RESET_EV],
             sb.mode_seen[dedb_pkg::MODE_CLEAR_ALL]);
    $display("%0d cycle starts; %0d rejected; stored count up to %0d, occurrences up to %0d.",
             sb.mode_seen[dedb_pkg::MODE_CYCLE_START], sb.rejected, sb.peak_stored,
             sb.peak_occ);
    if (sb.failures == 0) begin
      $display("diagnostic_event_debounce_status_tb passed");
    end else begin
      $display("diagnostic_event_debounce_status_tb failed");
    end
    $finish;
  end

endmodule
